// File: rtl/md5d_pkg.sv
// shared types, constants and round tables for the md5 digest block
package md5d_pkg;

  localparam logic [1:0] REQ_BYTE   = 2'd0;
  localparam logic [1:0] REQ_LAST   = 2'd1;
  localparam logic [1:0] REQ_FINISH = 2'd2;

  localparam logic [31:0] INIT_A = 32'h67452301;
  localparam logic [31:0] INIT_B = 32'hefcdab89;
  localparam logic [31:0] INIT_C = 32'h98badcfe;
  localparam logic [31:0] INIT_D = 32'h10325476;

  localparam logic [7:0] PAD_BYTE  = 8'h80;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [3:0] LEN_LO_WORD = 4'd14;
  localparam logic [3:0] LEN_HI_WORD = 4'd15;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    BLK_RAW,
    BLK_PAD1,
    BLK_PAD2
  } blk_mode_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
  } abcd_t;

  function automatic logic [31:0] round_k(input logic [5:0] i);
    logic [31:0] k;
    unique case (i)
      6'd0:  k = 32'hd76aa478;  6'd1:  k = 32'he8c7b756;
      6'd2:  k = 32'h242070db;  6'd3:  k = 32'hc1bdceee;
      6'd4:  k = 32'hf57c0faf;  6'd5:  k = 32'h4787c62a;
      6'd6:  k = 32'ha8304613;  6'd7:  k = 32'hfd469501;
      6'd8:  k = 32'h698098d8;  6'd9:  k = 32'h8b44f7af;
      6'd10: k = 32'hffff5bb1;  6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122;  6'd13: k = 32'hfd987193;
      6'd14: k = 32'ha679438e;  6'd15: k = 32'h49b40821;
      6'd16: k = 32'hf61e2562;  6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51;  6'd19: k = 32'he9b6c7aa;
      6'd20: k = 32'hd62f105d;  6'd21: k = 32'h02441453;
      6'd22: k = 32'hd8a1e681;  6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6;  6'd25: k = 32'hc33707d6;
      6'd26: k = 32'hf4d50d87;  6'd27: k = 32'h455a14ed;
      6'd28: k = 32'ha9e3e905;  6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9;  6'd31: k = 32'h8d2a4c8a;
      6'd32: k = 32'hfffa3942;  6'd33: k = 32'h8771f681;
      6'd34: k = 32'h6d9d6122;  6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44;  6'd37: k = 32'h4bdecfa9;
      6'd38: k = 32'hf6bb4b60;  6'd39: k = 32'hbebfbc70;
      6'd40: k = 32'h289b7ec6;  6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085;  6'd43: k = 32'h04881d05;
      6'd44: k = 32'hd9d4d039;  6'd45: k = 32'he6db99e5;
      6'd46: k = 32'h1fa27cf8;  6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244;  6'd49: k = 32'h432aff97;
      6'd50: k = 32'hab9423a7;  6'd51: k = 32'hfc93a039;
      6'd52: k = 32'h655b59c3;  6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d;  6'd55: k = 32'h85845dd1;
      6'd56: k = 32'h6fa87e4f;  6'd57: k = 32'hfe2ce6e0;
      6'd58: k = 32'ha3014314;  6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82;  6'd61: k = 32'hbd3af235;
      6'd62: k = 32'h2ad7d2bb;  6'd63: k = 32'heb86d391;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    unique case ({i[5:4], i[1:0]})
      4'd0:  s = 5'd7;   4'd1:  s = 5'd12;  4'd2:  s = 5'd17;  4'd3:  s = 5'd22;
      4'd4:  s = 5'd5;   4'd5:  s = 5'd9;   4'd6:  s = 5'd14;  4'd7:  s = 5'd20;
      4'd8:  s = 5'd4;   4'd9:  s = 5'd11;  4'd10: s = 5'd16;  4'd11: s = 5'd23;
      4'd12: s = 5'd6;   4'd13: s = 5'd10;  4'd14: s = 5'd15;  4'd15: s = 5'd21;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  // message word used by round i
  function automatic logic [3:0] msg_index(input logic [5:0] i);
    logic [3:0] lo;
    logic [3:0] g;
    lo = i[3:0];
    unique case (i[5:4])
      2'd0:    g = lo;
      2'd1:    g = 4'((lo << 2) + lo + 4'd1);
      2'd2:    g = 4'((lo << 1) + lo + 4'd5);
      2'd3:    g = 4'((lo << 3) - lo);
      default: g = lo;
    endcase
    return g;
  endfunction

endpackage

// File: rtl/md5_message_digest_top.sv
// md5 digest engine: byte intake, block buffer, padding and round sequencer
//
// Input channel: one message byte per word with a request type (byte, last
// byte, or finish with no byte). Bytes are taken one per cycle while the block
// buffer fills. When the 64th byte of a block arrives, the shared round unit
// runs 64 rounds, one per cycle, then folds the result into the chaining
// value; intake is stalled meanwhile.
// At the end of a message the padded final block is compressed, with one more
// block when fewer than nine bytes of the block are free or the last byte
// fills a block; then the four digest words A, B, C, D appear on the
// output channel in order, last_word set on D.
// The input stays stalled until D has been taken; a stalled output word holds.
// Request code 3 is taken and ignored.
// Reset loads the standard initial chaining value and clears the byte count;
// the same happens after each digest, ready for the next message.
module md5_message_digest_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [7:0]  in_data_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_digest_word,
  output logic [1:0]  out_word_index,
  output logic        out_last_word
);

  md5d_pkg::state_t    state_r, state_nxt;
  md5d_pkg::blk_mode_t mode_r, mode_nxt;
  md5d_pkg::abcd_t     wk_r, rnd_out, cv_sum, start_val;

  logic [31:0] cv_r [4];
  logic [31:0] blk_mem_r [16];
  logic [60:0] cnt_r;
  logic [5:0]  rnd_r;
  logic [1:0]  oidx_r;
  logic        fin_r;

  logic        take_byte, start_blk, set_fin, msg_done, blk_full;
  logic [5:0]  pos;
  logic [3:0]  g;
  logic [31:0] raw_word, msg_word;
  logic [63:0] bit_len;
  logic        len_here;

  assign pos      = cnt_r[5:0];
  assign blk_full = (pos == 6'h3F);
  assign bit_len  = {cnt_r, 3'b000};

  // message word for the current round, with padding laid over on the fly
  assign g        = md5d_pkg::msg_index(rnd_r);
  assign raw_word = blk_mem_r[g];
  assign len_here = (mode_r == md5d_pkg::BLK_PAD2) ||
                    ((mode_r == md5d_pkg::BLK_PAD1) && (pos[5:3] != 3'b111));

  always_comb begin
    logic [5:0] p;
    msg_word = raw_word;
    for (int l = 0; l < 4; l++) begin
      p = {g, 2'(l)};
      if (mode_r == md5d_pkg::BLK_PAD2) begin
        msg_word[8*l +: 8] = 8'h00;
      end else if (mode_r == md5d_pkg::BLK_PAD1) begin
        if (p == pos) begin
          msg_word[8*l +: 8] = md5d_pkg::PAD_BYTE;
        end else if (p > pos) begin
          msg_word[8*l +: 8] = 8'h00;
        end
      end
    end
    if (len_here && g == md5d_pkg::LEN_LO_WORD) begin
      msg_word = bit_len[31:0];
    end else if (len_here && g == md5d_pkg::LEN_HI_WORD) begin
      msg_word = bit_len[63:32];
    end
  end

  md5d_round u_round (
    .cur      (wk_r),
    .rnd      (rnd_r),
    .msg_word (msg_word),
    .nxt      (rnd_out)
  );

  assign cv_sum.a = cv_r[0] + wk_r.a;
  assign cv_sum.b = cv_r[1] + wk_r.b;
  assign cv_sum.c = cv_r[2] + wk_r.c;
  assign cv_sum.d = cv_r[3] + wk_r.d;

  // sequencer
  always_comb begin
    state_nxt = state_r;
    mode_nxt  = mode_r;
    take_byte = 1'b0;
    start_blk = 1'b0;
    set_fin   = 1'b0;
    msg_done  = 1'b0;
    in_stall  = (state_r != md5d_pkg::ST_IDLE);
    out_valid = (state_r == md5d_pkg::ST_OUT);
    unique case (state_r)
      md5d_pkg::ST_IDLE: begin
        if (in_valid) begin
          case (in_req_type)
            md5d_pkg::REQ_BYTE: begin
              take_byte = 1'b1;
              if (blk_full) begin
                start_blk = 1'b1;
                mode_nxt  = md5d_pkg::BLK_RAW;
                state_nxt = md5d_pkg::ST_ROUND;
              end
            end
            md5d_pkg::REQ_LAST: begin
              take_byte = 1'b1;
              set_fin   = 1'b1;
              start_blk = 1'b1;
              mode_nxt  = blk_full ? md5d_pkg::BLK_RAW : md5d_pkg::BLK_PAD1;
              state_nxt = md5d_pkg::ST_ROUND;
            end
            md5d_pkg::REQ_FINISH: begin
              set_fin   = 1'b1;
              start_blk = 1'b1;
              mode_nxt  = md5d_pkg::BLK_PAD1;
              state_nxt = md5d_pkg::ST_ROUND;
            end
            default: ;
          endcase
        end
      end
      md5d_pkg::ST_ROUND: begin
        if (rnd_r == md5d_pkg::LAST_ROUND) begin
          state_nxt = md5d_pkg::ST_FOLD;
        end
      end
      md5d_pkg::ST_FOLD: begin
        if (mode_r == md5d_pkg::BLK_RAW && fin_r) begin
          start_blk = 1'b1;
          mode_nxt  = md5d_pkg::BLK_PAD1;
          state_nxt = md5d_pkg::ST_ROUND;
        end else if (mode_r == md5d_pkg::BLK_PAD1 && pos[5:3] == 3'b111) begin
          // no room for the length, it goes into one more block
          start_blk = 1'b1;
          mode_nxt  = md5d_pkg::BLK_PAD2;
          state_nxt = md5d_pkg::ST_ROUND;
        end else if (mode_r == md5d_pkg::BLK_RAW) begin
          state_nxt = md5d_pkg::ST_IDLE;
        end else begin
          state_nxt = md5d_pkg::ST_OUT;
        end
      end
      md5d_pkg::ST_OUT: begin
        if (!out_stall && oidx_r == 2'd3) begin
          msg_done  = 1'b1;
          state_nxt = md5d_pkg::ST_IDLE;
        end
      end
      default: state_nxt = md5d_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= md5d_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= md5d_pkg::BLK_RAW;
      fin_r  <= 1'b0;
      cnt_r  <= '0;
      rnd_r  <= '0;
      oidx_r <= '0;
      cv_r[0] <= md5d_pkg::INIT_A;
      cv_r[1] <= md5d_pkg::INIT_B;
      cv_r[2] <= md5d_pkg::INIT_C;
      cv_r[3] <= md5d_pkg::INIT_D;
    end else begin
      mode_r <= mode_nxt;
      if (set_fin) begin
        fin_r <= 1'b1;
      end
      if (take_byte) begin
        cnt_r <= cnt_r + 61'd1;
      end
      if (start_blk) begin
        rnd_r <= '0;
      end else if (state_r == md5d_pkg::ST_ROUND) begin
        rnd_r <= rnd_r + 6'd1;
      end
      if (state_r == md5d_pkg::ST_FOLD) begin
        cv_r[0] <= cv_sum.a;
        cv_r[1] <= cv_sum.b;
        cv_r[2] <= cv_sum.c;
        cv_r[3] <= cv_sum.d;
        oidx_r  <= '0;
      end
      if (state_r == md5d_pkg::ST_OUT && !out_stall) begin
        oidx_r <= oidx_r + 2'd1;
      end
      if (msg_done) begin
        fin_r   <= 1'b0;
        cnt_r   <= '0;
        cv_r[0] <= md5d_pkg::INIT_A;
        cv_r[1] <= md5d_pkg::INIT_B;
        cv_r[2] <= md5d_pkg::INIT_C;
        cv_r[3] <= md5d_pkg::INIT_D;
      end
    end
  end

  // working variables and block buffer
  always_comb begin
    if (state_r == md5d_pkg::ST_FOLD) begin
      start_val = cv_sum;
    end else begin
      start_val = {cv_r[0], cv_r[1], cv_r[2], cv_r[3]};
    end
  end

  always_ff @(posedge clk) begin
    if (start_blk) begin
      wk_r <= start_val;
    end else if (state_r == md5d_pkg::ST_ROUND) begin
      wk_r <= rnd_out;
    end
    if (take_byte) begin
      blk_mem_r[pos[5:2]][8*pos[1:0] +: 8] <= in_data_byte;
    end
  end

  assign out_digest_word = cv_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 2'd3);

endmodule

// File: rtl/md5d_round.sv
// one md5 round: boolean function, four-way add, rotate and final add
module md5d_round (
  input  md5d_pkg::abcd_t     cur,
  input  logic [5:0]          rnd,
  input  logic [31:0]         msg_word,
  output md5d_pkg::abcd_t     nxt
);

  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] dbl;
  logic [4:0]  amt;

  always_comb begin
    unique case (rnd[5:4])
      2'd0:    f = (cur.b & cur.c) | (~cur.b & cur.d);
      2'd1:    f = (cur.b & cur.d) | (cur.c & ~cur.d);
      2'd2:    f = cur.b ^ cur.c ^ cur.d;
      2'd3:    f = cur.c ^ (cur.b | ~cur.d);
      default: f = 32'h0;
    endcase
  end

  assign amt = md5d_pkg::rot_amt(rnd);
  assign sum = cur.a + f + md5d_pkg::round_k(rnd) + msg_word;
  // rotate left through a doubled word
  assign dbl = {sum, sum} << amt;

  assign nxt.a = cur.d;
  assign nxt.b = cur.b + dbl[63:32];
  assign nxt.c = cur.b;
  assign nxt.d = cur.c;

endmodule
